>>> design/assert_macros.svh
// assertion macros shared by the walker rtl
// depends on nothing; included by the top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// antecedent in a cycle implies consequent in the same cycle
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("walker check failed");
// condition must never hold outside reset
`define ASSERT_NEVER(lbl, clk, rst, cond) \
  lbl: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("walker check failed");
`else
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEVER(lbl, clk, rst, cond)
`endif
`endif

>>> design/gmw_pkg.sv
// shared types, codes and wrap helpers for the grid walker
// no dependencies; used by the two stores and the walker top level
package gmw_pkg;

  // command codes
  localparam logic [1:0] CMD_LOAD  = 2'd0;
  localparam logic [1:0] CMD_STEP  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;
  localparam logic [1:0] CMD_PLACE = 2'd3;

  // step directions
  localparam logic [1:0] DIR_XP = 2'd0;
  localparam logic [1:0] DIR_XM = 2'd1;
  localparam logic [1:0] DIR_YP = 2'd2;
  localparam logic [1:0] DIR_YM = 2'd3;

  // configuration register indexes
  localparam logic [1:0] CFG_WIDTH  = 2'd0;
  localparam logic [1:0] CFG_HEIGHT = 2'd1;
  localparam logic [1:0] CFG_SCALE  = 2'd2;

  // configuration reset values
  localparam logic [8:0]  WIDTH_RST  = 9'd256;
  localparam logic [8:0]  HEIGHT_RST = 9'd256;
  localparam logic [15:0] SCALE_RST  = 16'd4588;

  localparam logic [7:0] COUNT_MAX = 8'd255;

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_CALC  = 4'b0100,
    S_DONE  = 4'b1000
  } state_t;

  // memory port strobes
  typedef struct packed {
    logic rd_en;
    logic wr_en;
  } mem_ctl_t;

  // forward step with wrap at the active size
  function automatic logic [7:0] step_up(input logic [7:0] v, input logic [8:0] size);
    logic [8:0] sum;
    sum = {1'b0, v} + 9'd1;
    return (sum >= size) ? 8'd0 : sum[7:0];
  endfunction

  // backward step, also pulls a walker beyond a shrunk grid back inside
  function automatic logic [7:0] step_down(input logic [7:0] v, input logic [8:0] size);
    logic [8:0] last;
    last = size - 9'd1;
    return (v == 8'd0 || {1'b0, v} > size) ? last[7:0] : v - 8'd1;
  endfunction

endpackage

>>> design/gmw_channels.sv
// valid/ready channel interfaces for command items and result items
// depends on nothing but the handshake convention
interface gmw_item_if;
  logic       valid;
  logic       ready;
  logic [1:0] cmd;
  logic [7:0] pos_x;
  logic [7:0] pos_y;
  logic [7:0] pixel_value;
  logic [1:0] direction;
  logic [15:0] chance;

  modport source (output valid, cmd, pos_x, pos_y, pixel_value, direction, chance,
                  input ready);
  modport sink   (input valid, cmd, pos_x, pos_y, pixel_value, direction, chance,
                  output ready);
endinterface

interface gmw_result_if;
  logic       valid;
  logic       ready;
  logic [7:0] walker_col;
  logic [7:0] walker_row;
  logic       moved;
  logic [7:0] count_here;
  logic [7:0] peak_count;

  modport source (output valid, walker_col, walker_row, moved, count_here, peak_count,
                  input ready);
  modport sink   (input valid, walker_col, walker_row, moved, count_here, peak_count,
                  output ready);
endinterface

>>> design/gmw_visit_store.sv
// visit-count memory with a clearing sweep after reset
// depends on gmw_pkg for the port strobe struct
module gmw_visit_store #(
  parameter int AW = 16
) (
  input  logic              clk,
  input  logic              rst,
  input  gmw_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     rd_addr,
  input  logic [AW-1:0]     wr_addr,
  input  logic [7:0]        wr_data,
  output logic [7:0]        rd_data,
  output logic              busy
);

  logic [7:0]    mem [2**AW];
  logic [AW-1:0] clr_addr;

  // clearing sweep, one entry a cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      clr_addr <= '0;
    end else if (busy) begin
      clr_addr <= clr_addr + AW'(1'b1);
      if (clr_addr == {AW{1'b1}}) begin
        busy <= 1'b0;
      end
    end
  end

  // single write port, registered read
  always_ff @(posedge clk) begin
    if (busy) begin
      mem[clr_addr] <= 8'd0;
    end else if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

>>> design/gmw_target_store.sv
// target image memory: one write port, two registered read ports
// depends on gmw_pkg for the port strobe struct
module gmw_target_store #(
  parameter int AW = 16
) (
  input  logic              clk,
  input  gmw_pkg::mem_ctl_t ctl,
  input  logic [AW-1:0]     wr_addr,
  input  logic [7:0]        wr_data,
  input  logic [AW-1:0]     rd_addr_a,
  input  logic [AW-1:0]     rd_addr_b,
  output logic [7:0]        rd_data_a,
  output logic [7:0]        rd_data_b
);

  logic [7:0] mem [2**AW];

  // image load and the two neighbour reads
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd_en) begin
      rd_data_a <= mem[rd_addr_a];
      rd_data_b <= mem[rd_addr_b];
    end
  end

endmodule

>>> design/gmw_accept_test.sv
// metropolis acceptance test: registered products, compare after
// depends on nothing beyond its ports
module gmw_accept_test (
  input  logic        clk,
  input  logic        capture,
  input  logic [15:0] chance,
  input  logic [7:0]  mine,
  input  logic [7:0]  other,
  input  logic [15:0] scale,
  output logic        take
);

  logic [24:0] lhs;
  logic [23:0] rhs;
  logic        uphill;

  // chance*(mine+other) against mine*scale
  always_ff @(posedge clk) begin
    if (capture) begin
      lhs    <= 25'(chance) * (25'(mine) + 25'(other));
      rhs    <= 24'(mine) * 24'(scale);
      uphill <= (other >= mine);
    end
  end

  // accept uphill, or downhill unless the draw falls below the rejection weight
  assign take = uphill || !(lhs < {1'b0, rhs});

endmodule

>>> design/grid_metropolis_walker.sv
// Grid walker sampling an 8-bit target image by a Metropolis rule. A command
// beat is accepted in the idle state, where the memories are read; the next
// edge writes the updated visit count back and forms the acceptance products,
// and in the done state, once the result side is free, the walker moves and
// the result is registered. The next beat is taken only after that, back in
// the idle state, so a result that waits holds the sequencer and the input.
// The calc and done states serve the registered memory read, the visit-count
// write-back and the registered acceptance decision.
// After reset the visit memory is cleared one entry a cycle, and no item is
// taken before every entry is cleared; configuration writes are taken at all
// times and belong between items.
`include "assert_macros.svh"

module grid_metropolis_walker #(
  parameter int MAX_WIDTH  = 256,
  parameter int MAX_HEIGHT = 256
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  gmw_item_if.sink    item,
  gmw_result_if.source result
);

  localparam int CW = (MAX_WIDTH > 256) ? 8 : $clog2(MAX_WIDTH);
  localparam int RW = (MAX_HEIGHT > 256) ? 8 : $clog2(MAX_HEIGHT);
  localparam int AW = CW + RW;
  localparam logic [8:0] COL_LIM = (MAX_WIDTH >= 256) ? 9'd256 : 9'(MAX_WIDTH);
  localparam logic [8:0] ROW_LIM = (MAX_HEIGHT >= 256) ? 9'd256 : 9'(MAX_HEIGHT);

  logic [8:0]  width_in_use;
  logic [8:0]  height_in_use;
  logic [15:0] reject_scale;

  gmw_pkg::state_t state, state_next;

  logic [7:0] cur_col, cur_row, peak_reg;
  logic [1:0] cmd_r;
  logic [7:0] pos_x_r, pos_y_r, nb_col, nb_row, count_r;
  logic [15:0] chance_r;
  logic       in_store_r, place_ok_r;

  logic [8:0] w_act, h_act;
  logic       accept, in_store_c, out_free, move_ok;
  logic [7:0] nb_col_c, nb_row_c, cnt_inc;
  logic [AW-1:0] here_addr, pos_addr, nb_addr;

  gmw_pkg::mem_ctl_t vis_ctl, tgt_ctl;
  logic [7:0] vis_rd, tgt_here, tgt_nb;
  logic       vis_busy;

  logic       out_valid, out_moved;
  logic [7:0] out_col, out_row, out_count, out_peak;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      width_in_use  <= gmw_pkg::WIDTH_RST;
      height_in_use <= gmw_pkg::HEIGHT_RST;
      reject_scale  <= gmw_pkg::SCALE_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        gmw_pkg::CFG_WIDTH:  width_in_use  <= cfg_data[8:0];
        gmw_pkg::CFG_HEIGHT: height_in_use <= cfg_data[8:0];
        gmw_pkg::CFG_SCALE:  reject_scale  <= cfg_data;
        default: ;
      endcase
    end
  end

  // active grid size, zero taken as one, limited by storage
  assign w_act = (width_in_use == 9'd0) ? 9'd1 :
                 ((width_in_use > COL_LIM) ? COL_LIM : width_in_use);
  assign h_act = (height_in_use == 9'd0) ? 9'd1 :
                 ((height_in_use > ROW_LIM) ? ROW_LIM : height_in_use);

  // handshake and addresses
  assign item.ready = (state == gmw_pkg::S_IDLE);
  assign accept     = item.valid && item.ready;
  assign in_store_c = ({1'b0, item.pos_x} < COL_LIM) && ({1'b0, item.pos_y} < ROW_LIM);
  assign here_addr  = {cur_row[RW-1:0], cur_col[CW-1:0]};
  assign pos_addr   = {item.pos_y[RW-1:0], item.pos_x[CW-1:0]};
  assign nb_addr    = {nb_row_c[RW-1:0], nb_col_c[CW-1:0]};

  // proposed neighbour with wraparound
  always_comb begin
    nb_col_c = cur_col;
    nb_row_c = cur_row;
    case (item.direction)
      gmw_pkg::DIR_XP: nb_col_c = gmw_pkg::step_up(cur_col, w_act);
      gmw_pkg::DIR_XM: nb_col_c = gmw_pkg::step_down(cur_col, w_act);
      gmw_pkg::DIR_YP: nb_row_c = gmw_pkg::step_up(cur_row, h_act);
      gmw_pkg::DIR_YM: nb_row_c = gmw_pkg::step_down(cur_row, h_act);
      default: ;
    endcase
  end

  // memory strobes
  always_comb begin
    vis_ctl.rd_en = accept;
    vis_ctl.wr_en = (state == gmw_pkg::S_CALC) && (cmd_r == gmw_pkg::CMD_STEP);
    tgt_ctl.rd_en = accept && (item.cmd == gmw_pkg::CMD_STEP);
    tgt_ctl.wr_en = accept && (item.cmd == gmw_pkg::CMD_LOAD) && in_store_c;
  end

  assign cnt_inc = (vis_rd == gmw_pkg::COUNT_MAX) ? gmw_pkg::COUNT_MAX : vis_rd + 8'd1;

  gmw_visit_store #(.AW(AW)) u_visit (
    .clk     (clk),
    .rst     (rst),
    .ctl     (vis_ctl),
    .rd_addr ((item.cmd == gmw_pkg::CMD_STEP) ? here_addr : pos_addr),
    .wr_addr (here_addr),
    .wr_data (cnt_inc),
    .rd_data (vis_rd),
    .busy    (vis_busy)
  );

  gmw_target_store #(.AW(AW)) u_target (
    .clk       (clk),
    .ctl       (tgt_ctl),
    .wr_addr   (pos_addr),
    .wr_data   (item.pixel_value),
    .rd_addr_a (here_addr),
    .rd_addr_b (nb_addr),
    .rd_data_a (tgt_here),
    .rd_data_b (tgt_nb)
  );

  gmw_accept_test u_accept (
    .clk     (clk),
    .capture (state == gmw_pkg::S_CALC),
    .chance  (chance_r),
    .mine    (tgt_here),
    .other   (tgt_nb),
    .scale   (reject_scale),
    .take    (move_ok)
  );

  // sequencer
  assign out_free = !out_valid || result.ready;

  always_comb begin
    state_next = state;
    case (state)
      gmw_pkg::S_CLEAR: if (!vis_busy) state_next = gmw_pkg::S_IDLE;
      gmw_pkg::S_IDLE:  if (accept) state_next = gmw_pkg::S_CALC;
      gmw_pkg::S_CALC:  state_next = gmw_pkg::S_DONE;
      gmw_pkg::S_DONE:  if (out_free) state_next = gmw_pkg::S_IDLE;
      default:          state_next = gmw_pkg::S_CLEAR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= gmw_pkg::S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // captured command beat
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r      <= item.cmd;
      pos_x_r    <= item.pos_x;
      pos_y_r    <= item.pos_y;
      chance_r   <= item.chance;
      nb_col     <= nb_col_c;
      nb_row     <= nb_row_c;
      in_store_r <= in_store_c;
      place_ok_r <= ({1'b0, item.pos_x} < w_act) && ({1'b0, item.pos_y} < h_act);
    end
  end

  // count of this beat
  always_ff @(posedge clk) begin
    if (state == gmw_pkg::S_CALC) begin
      if (cmd_r == gmw_pkg::CMD_STEP) begin
        count_r <= cnt_inc;
      end else if (cmd_r == gmw_pkg::CMD_READ && in_store_r) begin
        count_r <= vis_rd;
      end else begin
        count_r <= 8'd0;
      end
    end
  end

  // walker position and peak count
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_col  <= 8'd0;
      cur_row  <= 8'd0;
      peak_reg <= 8'd0;
    end else begin
      if (state == gmw_pkg::S_CALC && cmd_r == gmw_pkg::CMD_STEP && cnt_inc > peak_reg) begin
        peak_reg <= cnt_inc;
      end
      if (state == gmw_pkg::S_DONE && out_free) begin
        if (cmd_r == gmw_pkg::CMD_STEP && move_ok) begin
          cur_col <= nb_col;
          cur_row <= nb_row;
        end else if (cmd_r == gmw_pkg::CMD_PLACE && place_ok_r) begin
          cur_col <= pos_x_r;
          cur_row <= pos_y_r;
        end
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == gmw_pkg::S_DONE && out_free) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == gmw_pkg::S_DONE && out_free) begin
      out_moved <= (cmd_r == gmw_pkg::CMD_STEP) && move_ok;
      out_count <= count_r;
      out_peak  <= peak_reg;
      if (cmd_r == gmw_pkg::CMD_STEP && move_ok) begin
        out_col <= nb_col;
        out_row <= nb_row;
      end else if (cmd_r == gmw_pkg::CMD_PLACE && place_ok_r) begin
        out_col <= pos_x_r;
        out_row <= pos_y_r;
      end else begin
        out_col <= cur_col;
        out_row <= cur_row;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.walker_col = out_col;
  assign result.walker_row = out_row;
  assign result.moved      = out_moved;
  assign result.count_here = out_count;
  assign result.peak_count = out_peak;

  // checks
  `ASSERT_NEVER(a_walker_in_store, clk, rst, ({1'b0, cur_col} >= COL_LIM) || ({1'b0, cur_row} >= ROW_LIM))
  `ASSERT_IMPLIES(a_peak_keeps, clk, rst, !$past(rst), peak_reg >= $past(peak_reg))
  `ASSERT_IMPLIES(a_visit_wr_calc, clk, rst, vis_ctl.wr_en, state == gmw_pkg::S_CALC)
  `ASSERT_IMPLIES(a_no_beat_clear, clk, rst, vis_busy, !item.ready)

endmodule

>>> verif/tb_top.sv
// self-checking testbench for grid_metropolis_walker: own walk predictor, scoreboard class
// depends on gmw_pkg, the gmw_item_if/gmw_result_if channel interfaces and the walker rtl
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned LONG_HOLD   = 300;
  localparam int unsigned TAIL_CYCLES = 10;
  localparam int unsigned GRID        = 256;

  // one command beat and one result beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [7:0]  pos_x;
    logic [7:0]  pos_y;
    logic [7:0]  pixel_value;
    logic [1:0]  direction;
    logic [15:0] chance;
  } walk_cmd_t;

  typedef struct packed {
    logic [7:0] walker_col;
    logic [7:0] walker_row;
    logic       moved;
    logic [7:0] count_here;
    logic [7:0] peak_count;
  } walk_result_t;

  // walker state shadow, expected result queue and field checks
  class walk_scoreboard;
    int unsigned width_reg = 32'(gmw_pkg::WIDTH_RST);
    int unsigned height_reg = 32'(gmw_pkg::HEIGHT_RST);
    int unsigned scale_reg = 32'(gmw_pkg::SCALE_RST);
    int unsigned col;
    int unsigned row;
    int unsigned peak;
    byte unsigned visits[GRID*GRID];
    byte unsigned pixels[GRID*GRID];
    bit loaded[GRID*GRID];
    walk_result_t expected_results[$];
    int errors;

    // register value to the grid size actually used
    function int unsigned span(int unsigned r);
      if (r == 0) return 1;
      if (r > GRID) return GRID;
      return r;
    endfunction

    function void write_reg(logic [1:0] idx, int unsigned v);
      case (idx)
        gmw_pkg::CFG_WIDTH: width_reg = v & 'h1ff;
        gmw_pkg::CFG_HEIGHT: height_reg = v & 'h1ff;
        gmw_pkg::CFG_SCALE: scale_reg = v & 'hffff;
        default: ;
      endcase
    endfunction

    // neighbour proposed from the current cell, wrapping at the active size
    function void propose(logic [1:0] dir, output int unsigned tc, output int unsigned tr);
      int unsigned w;
      int unsigned h;
      w = span(width_reg);
      h = span(height_reg);
      tc = col;
      tr = row;
      case (dir)
        gmw_pkg::DIR_XP: tc = (col + 1 >= w) ? 0 : col + 1;
        gmw_pkg::DIR_XM: tc = (col == 0 || col > w) ? w - 1 : col - 1;
        gmw_pkg::DIR_YP: tr = (row + 1 >= h) ? 0 : row + 1;
        default: tr = (row == 0 || row > h) ? h - 1 : row - 1;
      endcase
    endfunction

    // smallest chance that still accepts a downhill move; a random chance when the move is uphill
    function int unsigned chance_cut(logic [1:0] dir);
      int unsigned tc;
      int unsigned tr;
      longint unsigned mine;
      longint unsigned other;
      propose(dir, tc, tr);
      mine = 64'(pixels[row*GRID + col]);
      other = 64'(pixels[tr*GRID + tc]);
      if (other >= mine) return $urandom_range(0, 65535);
      return 32'((mine * scale_reg + mine + other - 1) / (mine + other));
    endfunction

    function walk_result_t predict_walk(walk_cmd_t c);
      walk_result_t r;
      int unsigned w;
      int unsigned h;
      int unsigned here;
      int unsigned cnt;
      int unsigned tc;
      int unsigned tr;
      longint unsigned mine;
      longint unsigned other;
      bit take;
      w = span(width_reg);
      h = span(height_reg);
      r = '0;
      cnt = 0;
      case (c.cmd)
        gmw_pkg::CMD_LOAD: begin
          pixels[{c.pos_y, c.pos_x}] = c.pixel_value;
          loaded[{c.pos_y, c.pos_x}] = 1'b1;
        end
        gmw_pkg::CMD_STEP: begin
          here = row*GRID + col;
          cnt = 32'(visits[here]);
          if (cnt < gmw_pkg::COUNT_MAX) cnt++;
          visits[here] = 8'(cnt);
          if (cnt > peak) peak = cnt;
          propose(c.direction, tc, tr);
          mine = 64'(pixels[here]);
          other = 64'(pixels[tr*GRID + tc]);
          if (other >= mine) take = 1'b1;
          else take = !(64'(c.chance) * (mine + other) < mine * scale_reg);
          if (take) begin
            col = tc;
            row = tr;
            r.moved = 1'b1;
          end
        end
        gmw_pkg::CMD_READ: cnt = 32'(visits[{c.pos_y, c.pos_x}]);
        default: begin
          if (c.pos_x < w && c.pos_y < h) begin
            col = 32'(c.pos_x);
            row = 32'(c.pos_y);
          end
        end
      endcase
      r.walker_col = 8'(col);
      r.walker_row = 8'(row);
      r.count_here = 8'(cnt);
      r.peak_count = 8'(peak);
      return r;
    endfunction

    function void note_command(walk_cmd_t c);
      expected_results.push_back(predict_walk(c));
    endfunction

    function int pending();
      return expected_results.size();
    endfunction

    task report_mismatch(string what, int got, int want);
      errors++;
      $display("[%0t] mismatch %s: got %0d expected %0d", $realtime, what, got, want);
    endtask

    task check_beat(walk_result_t got);
      walk_result_t want;
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result beat", 1, 0);
        return;
      end
      want = expected_results.pop_front();
      if (got.walker_col !== want.walker_col)
        report_mismatch("walker_col", 32'(got.walker_col), 32'(want.walker_col));
      if (got.walker_row !== want.walker_row)
        report_mismatch("walker_row", 32'(got.walker_row), 32'(want.walker_row));
      if (got.moved !== want.moved)
        report_mismatch("moved", 32'(got.moved), 32'(want.moved));
      if (got.count_here !== want.count_here)
        report_mismatch("count_here", 32'(got.count_here), 32'(want.count_here));
      if (got.peak_count !== want.peak_count)
        report_mismatch("peak_count", 32'(got.peak_count), 32'(want.peak_count));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int unsigned cycles = 0;
  bit          send_idle;
  bit          recv_idle;
  bit          hold_req;
  walk_scoreboard sb;

  gmw_item_if   item_ch();
  gmw_result_if result_ch();

  grid_metropolis_walker dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item_ch),
    .result    (result_ch)
  );

  // clock
  initial begin
    forever #5 clk = ~clk;
  end

  // run limit
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // command beat, with a random gap in front when gaps are enabled
  task automatic send_beat(walk_cmd_t c);
    int unsigned gap;
    gap = send_idle ? $urandom_range(0, 7) : 0;
    if (gap > 0) begin
      @(negedge clk);
      item_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    item_ch.valid       <= 1'b1;
    item_ch.cmd         <= c.cmd;
    item_ch.pos_x       <= c.pos_x;
    item_ch.pos_y       <= c.pos_y;
    item_ch.pixel_value <= c.pixel_value;
    item_ch.direction   <= c.direction;
    item_ch.chance      <= c.chance;
    do @(posedge clk); while (!item_ch.ready);
    sb.note_command(c);
  endtask

  task automatic send_cmd(logic [1:0] op, int unsigned x, int unsigned y, int unsigned pix);
    walk_cmd_t c;
    c.cmd = op;
    c.pos_x = 8'(x);
    c.pos_y = 8'(y);
    c.pixel_value = 8'(pix);
    c.direction = 2'($urandom_range(0, 3));
    c.chance = 16'($urandom_range(0, 65535));
    send_beat(c);
  endtask

  // step, loading any target cell it would read that is still unknown
  task automatic take_step(logic [1:0] dir, int pick);
    int unsigned tc;
    int unsigned tr;
    int unsigned cut;
    walk_cmd_t c;
    if (!sb.loaded[sb.row*GRID + sb.col])
      send_cmd(gmw_pkg::CMD_LOAD, sb.col, sb.row, $urandom_range(0, 255));
    sb.propose(dir, tc, tr);
    if (!sb.loaded[tr*GRID + tc])
      send_cmd(gmw_pkg::CMD_LOAD, tc, tr, $urandom_range(0, 255));
    c.cmd = gmw_pkg::CMD_STEP;
    c.direction = dir;
    c.pos_x = 8'($urandom_range(0, 255));
    c.pos_y = 8'($urandom_range(0, 255));
    c.pixel_value = 8'($urandom_range(0, 255));
    if (pick >= 0) begin
      c.chance = 16'(pick);
    end else begin
      case ($urandom_range(0, 3))
        0: c.chance = $urandom_range(0, 1) ? 16'hffff : 16'h0000;
        1: begin
          cut = sb.chance_cut(dir);
          if (cut > 0 && $urandom_range(0, 1)) cut = cut - 1;
          c.chance = 16'(cut);
        end
        default: c.chance = 16'($urandom_range(0, 65535));
      endcase
    end
    send_beat(c);
  endtask

  task automatic random_beat(int unsigned step_pct);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    logic [1:0] op;
    if ($urandom_range(0, 99) < step_pct) begin
      take_step(2'($urandom_range(0, 3)), -1);
    end else begin
      w = sb.span(sb.width_reg);
      h = sb.span(sb.height_reg);
      case ($urandom_range(0, 2))
        0: op = gmw_pkg::CMD_LOAD;
        1: op = gmw_pkg::CMD_READ;
        default: op = gmw_pkg::CMD_PLACE;
      endcase
      // mostly inside the active grid, sometimes anywhere
      x = ($urandom_range(0, 3) != 0) ? $urandom_range(0, w - 1) : $urandom_range(0, 255);
      y = ($urandom_range(0, 3) != 0) ? $urandom_range(0, h - 1) : $urandom_range(0, 255);
      send_cmd(op, x, y, $urandom_range(0, 255));
    end
  endtask

  task automatic write_cfg(logic [1:0] idx, int unsigned v);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= 16'(v);
    @(posedge clk);
    sb.write_reg(idx, v);
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  task automatic drain();
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // one setting of the registers, then a burst of random beats
  task automatic run_phase(int unsigned wv, int unsigned hv, int unsigned sv, int beats,
                           int unsigned step_pct, bit gaps, bit stalls, bit hold);
    drain();
    write_cfg(gmw_pkg::CFG_WIDTH, wv);
    write_cfg(gmw_pkg::CFG_HEIGHT, hv);
    write_cfg(gmw_pkg::CFG_SCALE, sv);
    send_idle = gaps;
    recv_idle = stalls;
    hold_req = hold;
    repeat (beats) random_beat(step_pct);
    @(negedge clk);
    item_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, one long hold on request, check every beat
  initial begin
    int unsigned stall;
    walk_result_t got;
    wait (rst == 1'b0);
    forever begin
      stall = recv_idle ? $urandom_range(0, 7) : 0;
      if (hold_req) begin
        hold_req = 1'b0;
        stall = LONG_HOLD;
      end
      if (stall > 0) begin
        @(negedge clk);
        result_ch.ready <= 1'b0;
        repeat (stall - 1) @(negedge clk);
      end
      @(negedge clk);
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (!result_ch.valid);
      got.walker_col = result_ch.walker_col;
      got.walker_row = result_ch.walker_row;
      got.moved      = result_ch.moved;
      got.count_here = result_ch.count_here;
      got.peak_count = result_ch.peak_count;
      sb.check_beat(got);
    end
  end

  // reset, directed walk, random phases, end of run
  initial begin
    sb = new();
    cfg_wr_en = 1'b0;
    cfg_index = gmw_pkg::CFG_WIDTH;
    cfg_data = '0;
    item_ch.valid = 1'b0;
    item_ch.cmd = gmw_pkg::CMD_LOAD;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.pixel_value = '0;
    item_ch.direction = gmw_pkg::DIR_XP;
    item_ch.chance = '0;
    result_ch.ready = 1'b0;
    send_idle = 1'b1;
    recv_idle = 1'b1;
    hold_req = 1'b0;
    repeat (2) @(negedge clk);
    rst <= 1'b0;

    // directed: wrap at both grid edges, accept and reject around the threshold
    send_cmd(gmw_pkg::CMD_LOAD, 0, 0, 200);
    send_cmd(gmw_pkg::CMD_LOAD, 1, 0, 255);
    send_cmd(gmw_pkg::CMD_LOAD, 255, 0, 10);
    send_cmd(gmw_pkg::CMD_LOAD, 0, 1, 100);
    send_cmd(gmw_pkg::CMD_LOAD, 0, 255, 0);
    take_step(gmw_pkg::DIR_XP, 0);
    send_cmd(gmw_pkg::CMD_PLACE, 0, 0, 0);
    take_step(gmw_pkg::DIR_XM, 0);
    take_step(gmw_pkg::DIR_XM, 65535);
    take_step(gmw_pkg::DIR_XP, 0);
    take_step(gmw_pkg::DIR_YM, 4587);
    take_step(gmw_pkg::DIR_YM, 4588);
    take_step(gmw_pkg::DIR_YP, 0);
    take_step(gmw_pkg::DIR_YP, 65535);
    send_cmd(gmw_pkg::CMD_READ, 0, 0, 0);
    send_cmd(gmw_pkg::CMD_READ, 255, 255, 255);
    send_cmd(gmw_pkg::CMD_PLACE, 255, 255, 255);
    send_cmd(gmw_pkg::CMD_LOAD, 255, 255, 255);
    send_cmd(gmw_pkg::CMD_PLACE, 0, 0, 0);
    @(negedge clk);
    item_ch.valid <= 1'b0;

    // small grid, no rejection weight
    run_phase(4, 3, 0, 80, 60, 1'b1, 1'b1, 1'b0);
    // single cell: counts saturate; long result hold while beats keep coming
    run_phase(1, 1, 65535, 290, 95, 1'b0, 1'b1, 1'b1);
    // full grid, back to back on both sides
    run_phase(256, 256, 4588, 40, 60, 1'b0, 1'b0, 1'b0);
    // zero width and oversized height, walker pulled back inside
    run_phase(0, 511, 32768, 50, 70, 1'b1, 1'b0, 1'b0);
    run_phase(2, 2, 65535, 60, 60, 1'b1, 1'b1, 1'b0);
    run_phase(300, 7, 12345, 40, 50, 1'b1, 1'b1, 1'b0);

    drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule
